// ===== hw/rtl/mie_pkg.sv =====
package mie_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_STEP,
        ST_ADJ,
        ST_OUT
    } state_t;

endpackage

// ===== hw/rtl/modular_inverse_ext_euclid_top.sv =====
// Modular inverse by the extended Euclidean algorithm. A beat on s_* carries value_a and the
// modulus n; one beat on m_* returns the inverse x in 0..n-1 with a*x = 1 (mod n) and exists
// set, or inverse 0 with exists clear when gcd(a,n) is not 1 or n is 0 (n = 1 gives 0, set).
// One item at a time: s_tready is high only while the block is idle. Each Euclid quotient step
// runs through a single restoring shift-subtract divider that also accumulates q times the
// Bezout coefficient, one quotient bit per cycle; a step state then swaps the operands. An
// item takes k quotient steps, where k is at most about 1.44 * WIDTH + 2 and far fewer
// typically; after the last step an adjust state and an output state give the result.
// A finished result waits in the output register while the next item is accepted.
module modular_inverse_ext_euclid_top #(
    parameter int WIDTH = 32
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // value_a [WIDTH-1:0], modulus [2*WIDTH-1:WIDTH], zero padded
    input  logic [((2*WIDTH+7)/8)*8-1:0]         s_tdata,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // inverse [WIDTH-1:0], exists [WIDTH], zero padded
    output logic [((WIDTH+1+7)/8)*8-1:0]         m_tdata
);

    localparam int OUT_W = ((WIDTH + 1 + 7) / 8) * 8;
    localparam int CW    = $clog2(WIDTH);

    mie_pkg::state_t state_reg, state_next;

    logic [WIDTH-1:0]        quo_reg, quo_next;     // dividend shifting out, quotient in
    logic [WIDTH-1:0]        div_reg, div_next;     // current divisor (small)
    logic [WIDTH-1:0]        prem_reg, prem_next;   // partial remainder
    logic [WIDTH-1:0]        n_reg, n_next;
    logic signed [WIDTH:0]   cb_reg, cb_next;       // coefficient of big
    logic signed [WIDTH:0]   cs_reg, cs_next;       // coefficient of small
    logic signed [WIDTH+1:0] acc_reg, acc_next;     // q * cs
    logic [CW-1:0]           cnt_reg, cnt_next;
    logic                    ok_reg, ok_next;
    logic                    m_tvalid_reg, m_tvalid_next;
    logic [OUT_W-1:0]        m_tdata_reg, m_tdata_next;

    logic [WIDTH:0]          pr;
    logic [WIDTH+1:0]        pdiff;
    logic                    qbit;
    logic signed [WIDTH+1:0] cs_ext;
    logic signed [WIDTH+1:0] cdiff;
    logic [WIDTH:0]          cadj;
    logic [WIDTH:0]          rdiff;
    logic [WIDTH-1:0]        red;
    logic                    out_free;
    logic [WIDTH-1:0]        in_a;
    logic [WIDTH-1:0]        in_n;

    assign in_a = s_tdata[WIDTH-1:0];
    assign in_n = s_tdata[2*WIDTH-1:WIDTH];

    // divider step and coefficient accumulate
    assign pr     = {prem_reg, quo_reg[WIDTH-1]};
    assign pdiff  = {1'b0, pr} - {2'b00, div_reg};
    assign qbit   = ~pdiff[WIDTH+1];
    assign cs_ext = {cs_reg[WIDTH], cs_reg};
    assign cdiff  = {cb_reg[WIDTH], cb_reg} - acc_reg;
    assign cadj   = cs_reg + $signed({1'b0, n_reg});
    assign rdiff  = {1'b0, cs_reg[WIDTH-1:0]} - {1'b0, n_reg};
    assign red    = rdiff[WIDTH] ? cs_reg[WIDTH-1:0] : rdiff[WIDTH-1:0];

    assign out_free = ~m_tvalid_reg | m_tready;

    assign s_tready = (state_reg == mie_pkg::ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    always_comb
    begin
        state_next    = state_reg;
        quo_next      = quo_reg;
        div_next      = div_reg;
        prem_next     = prem_reg;
        n_next        = n_reg;
        cb_next       = cb_reg;
        cs_next       = cs_reg;
        acc_next      = acc_reg;
        cnt_next      = cnt_reg;
        ok_next       = ok_reg;
        m_tvalid_next = m_tvalid_reg & ~m_tready;
        m_tdata_next  = m_tdata_reg;

        unique case (state_reg)
            mie_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    n_next    = in_n;
                    quo_next  = in_a;
                    div_next  = in_n;
                    prem_next = '0;
                    acc_next  = '0;
                    cb_next   = (WIDTH+1)'(1);
                    cs_next   = '0;
                    cnt_next  = '0;
                    ok_next   = 1'b0;
                    // zero modulus: no inverse, skip straight to the result
                    state_next = (in_n == '0) ? mie_pkg::ST_OUT : mie_pkg::ST_DIV;
                end
            end
            mie_pkg::ST_DIV:
            begin
                prem_next = qbit ? pdiff[WIDTH-1:0] : pr[WIDTH-1:0];
                quo_next  = {quo_reg[WIDTH-2:0], qbit};
                acc_next  = (acc_reg <<< 1) + (qbit ? cs_ext : '0);
                if (cnt_reg == CW'(WIDTH - 1))
                begin
                    state_next = mie_pkg::ST_STEP;
                end
                else
                begin
                    cnt_next = cnt_reg + CW'(1);
                end
            end
            mie_pkg::ST_STEP:
            begin
                if (prem_reg == '0)
                begin
                    state_next = mie_pkg::ST_ADJ;
                end
                else
                begin
                    // advance: (big, small) <- (small, rem)
                    cb_next    = cs_reg;
                    cs_next    = cdiff[WIDTH:0];
                    quo_next   = div_reg;
                    div_next   = prem_reg;
                    prem_next  = '0;
                    acc_next   = '0;
                    cnt_next   = '0;
                    state_next = mie_pkg::ST_DIV;
                end
            end
            mie_pkg::ST_ADJ:
            begin
                ok_next = (div_reg == WIDTH'(1));
                if (cs_reg[WIDTH])
                begin
                    cs_next = cadj;
                end
                state_next = mie_pkg::ST_OUT;
            end
            mie_pkg::ST_OUT:
            begin
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = OUT_W'({ok_reg, ok_reg ? red : WIDTH'(0)});
                    state_next    = mie_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mie_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= mie_pkg::ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg     <= quo_next;
        div_reg     <= div_next;
        prem_reg    <= prem_next;
        n_reg       <= n_next;
        cb_reg      <= cb_next;
        cs_reg      <= cs_next;
        acc_reg     <= acc_next;
        cnt_reg     <= cnt_next;
        ok_reg      <= ok_next;
        m_tdata_reg <= m_tdata_next;
    end

endmodule

// ===== hw/rtl/mie_checker.sv =====
module mie_checker #(
    parameter int WIDTH = 32
) (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             s_tvalid,
    input logic                             s_tready,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [((WIDTH+1+7)/8)*8-1:0]     m_tdata
);

    // hold a stalled result beat
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // no inverse means a zero inverse field
    a_zero_when_none: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[WIDTH] |-> m_tdata[WIDTH-1:0] == '0)
        else $error("nonzero inverse without exists");

    // one item at a time: busy right after an accept
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while an item is in work");

    // a new result comes only out of a busy period
    a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result appeared without work");

endmodule

bind modular_inverse_ext_euclid_top mie_checker #(.WIDTH(WIDTH)) u_mie_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== tb/sv/modular_inverse_ext_euclid_top_tb.sv =====
`timescale 1ns / 100ps

module modular_inverse_ext_euclid_top_tb;

    localparam int WIDTH = 32;
    localparam int S_BITS = ((2*WIDTH+7)/8)*8;
    localparam int M_BITS = ((WIDTH+1+7)/8)*8;

    typedef logic [WIDTH-1:0] word_t;
    // Bezout coefficients need one bit more than the operands
    typedef logic [WIDTH:0] coef_t;

    typedef struct packed {
        word_t value_a;
        word_t modulus;
        word_t inverse;
        logic  exists;
    } inv_result_t;

    logic              clk;
    logic              rst_n;
    logic              s_tvalid;
    logic              s_tready;
    logic [S_BITS-1:0] s_tdata;
    logic              m_tvalid;
    logic              m_tready;
    logic [M_BITS-1:0] m_tdata;

    inv_result_t pending_inverses[$];

    int unsigned errors = 0;
    int unsigned pairs_sent = 0;
    int unsigned results_seen = 0;
    int unsigned inverses_found = 0;
    int          hold_cycles = 0;
    bit          gaps_off = 1'b0;
    bit          stalls_off = 1'b0;

    modular_inverse_ext_euclid_top #(
        .WIDTH(WIDTH)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    initial
    begin
        #(64'd40_000_000);
        $display("Simulation FAILED");
        $finish;
    end

    function automatic inv_result_t predict_inverse(word_t a, word_t n);
        inv_result_t r;
        word_t big;
        word_t little;
        word_t rem;
        word_t quot;
        coef_t c_big;
        coef_t c_small;
        coef_t c_next;
        coef_t mag;
        r.value_a = a;
        r.modulus = n;
        r.inverse = '0;
        r.exists = 1'b0;
        if (n != '0)
        begin
            big = a;
            little = n;
            c_big = coef_t'(1);
            c_small = '0;
            rem = big % little;
            quot = big / little;
            while (rem != '0)
            begin
                // wraps at WIDTH+1 bits; the true coefficient always fits
                c_next = c_big - coef_t'(quot) * c_small;
                c_big = c_small;
                c_small = c_next;
                big = little;
                little = rem;
                rem = big % little;
                quot = big / little;
            end
            if (little == word_t'(1))
            begin
                r.exists = 1'b1;
                if (c_small[WIDTH])
                begin
                    mag = -c_small;
                    rem = word_t'(mag % coef_t'(n));
                    r.inverse = (rem == '0) ? '0 : n - rem;
                end
                else
                    r.inverse = word_t'(c_small % coef_t'(n));
            end
        end
        return r;
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 15);
        return $urandom_range(30, 150);
    endfunction

    function automatic word_t fib_word(int unsigned k);
        logic [63:0] f0;
        logic [63:0] f1;
        logic [63:0] t;
        f0 = 0;
        f1 = 1;
        repeat (k)
        begin
            t = f0 + f1;
            f0 = f1;
            f1 = t;
        end
        return word_t'(f0);
    endfunction

    function automatic word_t rand_sized_word();
        int unsigned bits;
        logic [63:0] mask;
        bits = $urandom_range(1, WIDTH);
        mask = (64'd1 << bits) - 64'd1;
        return word_t'($urandom) & word_t'(mask);
    endfunction

    task automatic flag_mismatch(string what, word_t a, word_t n, word_t got, word_t want);
        if (errors < 40)
            $display("MISMATCH %s: a=%h n=%h got %h expected %h", what, a, n, got, want);
        errors++;
    endtask

    // Call at a falling edge; returns at the falling edge after the beat is taken.
    task automatic send_operands(word_t a, word_t n);
        int unsigned gap;
        gap = gaps_off ? 0 : pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {n, a};
        do
            @(posedge clk);
        while (!s_tready);
        pending_inverses.push_back(predict_inverse(a, n));
        pairs_sent++;
        @(negedge clk);
    endtask

    task automatic wait_drain();
        s_tvalid <= 1'b0;
        while (pending_inverses.size() != 0)
            @(negedge clk);
    endtask

    task automatic test_directed_cases();
        word_t f46;
        word_t f47;
        f46 = fib_word(46);
        f47 = fib_word(47);
        // zero modulus
        send_operands(32'h0000_0000, 32'h0000_0000);
        send_operands(32'h0000_0005, 32'h0000_0000);
        send_operands(32'hFFFF_FFFF, 32'h0000_0000);
        // modulus one
        send_operands(32'h0000_0000, 32'h0000_0001);
        send_operands(32'hFFFF_FFFF, 32'h0000_0001);
        // zero value, then a small coprime pair
        send_operands(32'h0000_0000, 32'h0000_0007);
        send_operands(32'h0000_0000, 32'hFFFF_FFFF);
        send_operands(32'h0000_0003, 32'h0000_0007);
        // value not below modulus, then other extreme pairs
        send_operands(32'h0000_000A, 32'h0000_0007);
        send_operands(32'h0000_0007, 32'h0000_0007);
        send_operands(32'hFFFF_FFFF, 32'hFFFF_FFFE);
        send_operands(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_operands(32'h0000_0001, 32'hFFFF_FFFF);
        send_operands(32'hFFFF_FFFE, 32'hFFFF_FFFF);
        send_operands(32'h0000_0002, 32'h0000_0004);
        send_operands(32'h8000_0000, 32'hFFFF_FFFF);
        send_operands(32'h0000_0003, 32'h8000_0000);
        send_operands(32'h0000_0001, 32'h0000_0002);
        // consecutive Fibonacci numbers take the most quotient steps
        send_operands(f46, f47);
        send_operands(f47, f46);
        send_operands(f47 - 32'd1, f47);
        wait_drain();
    endtask

    task automatic test_random_full_width();
        int unsigned k;
        repeat (450)
        begin
            if ($urandom_range(0, 19) == 0)
            begin
                k = $urandom_range(3, 47);
                send_operands(fib_word(k - 1), fib_word(k));
            end
            else
                send_operands(word_t'($urandom), word_t'($urandom));
        end
        wait_drain();
    endtask

    task automatic test_random_sizes();
        word_t n;
        int unsigned r;
        repeat (800)
        begin
            r = $urandom_range(0, 49);
            if (r == 0)
                n = '0;
            else if (r == 1)
                n = word_t'(1);
            else
                n = rand_sized_word();
            if ($urandom_range(0, 29) == 0)
                send_operands('0, n);
            else
                send_operands(rand_sized_word(), n);
        end
        wait_drain();
    endtask

    task automatic test_back_to_back();
        gaps_off = 1'b1;
        stalls_off = 1'b1;
        repeat (200)
            send_operands(word_t'($urandom), word_t'($urandom));
        wait_drain();
        gaps_off = 1'b0;
        stalls_off = 1'b0;
    endtask

    task automatic test_output_backpressure();
        // small operands finish fast, so the output register fills during the hold
        hold_cycles = 2000;
        gaps_off = 1'b1;
        repeat (60)
            send_operands(word_t'($urandom_range(0, 255)), word_t'($urandom_range(0, 255)));
        gaps_off = 1'b0;
        wait_drain();
    endtask

    initial
    begin : ready_driver
        int unsigned stall;
        stall = 0;
        m_tready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                hold_cycles--;
                m_tready <= 1'b0;
            end
            else if (stall > 0)
            begin
                stall--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
                if (!stalls_off && $urandom_range(0, 3) == 0)
                    stall = pick_gap();
            end
        end
    end

    always @(posedge clk)
    begin : result_check
        inv_result_t want;
        word_t got_inverse;
        logic got_exists;
        if (rst_n && m_tvalid && m_tready)
        begin
            got_inverse = m_tdata[WIDTH-1:0];
            got_exists = m_tdata[WIDTH];
            results_seen++;
            if (pending_inverses.size() == 0)
                flag_mismatch("unexpected beat", '0, '0, got_inverse, '0);
            else
            begin
                want = pending_inverses.pop_front();
                if (want.exists)
                    inverses_found++;
                if (got_inverse !== want.inverse)
                    flag_mismatch("inverse", want.value_a, want.modulus, got_inverse,
                                  want.inverse);
                if (got_exists !== want.exists)
                    flag_mismatch("exists", want.value_a, want.modulus, word_t'(got_exists),
                                  word_t'(want.exists));
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_directed_cases();
        test_random_full_width();
        test_random_sizes();
        test_back_to_back();
        test_output_backpressure();
        repeat (200) @(negedge clk);
        if (pending_inverses.size() != 0)
            flag_mismatch("results missing at end", '0, '0, '0,
                          word_t'(pending_inverses.size()));
        $display("Sent %0d operand pairs (edge cases, Fibonacci chains, mixed sizes).",
                 pairs_sent);
        $display("Checked %0d results: %0d with an inverse, %0d without.",
                 results_seen, inverses_found, results_seen - inverses_found);
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/mie_pkg.sv
hw/rtl/modular_inverse_ext_euclid_top.sv
hw/rtl/mie_checker.sv
tb/sv/modular_inverse_ext_euclid_top_tb.sv
